// ===== rtl/core/dual_channel_fir_lowpass_macros.svh =====
// Assertion macros for the filter top level.
// ASSERT_OFF set at compile time turns every check into an empty statement.
`ifndef DUAL_CHANNEL_FIR_LOWPASS_MACROS_SVH
`define DUAL_CHANNEL_FIR_LOWPASS_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, skipped while in reset
`define DCFL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcfl check failed");

// Next-cycle implication, skipped while in reset
`define DCFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcfl check failed");

`else

`define DCFL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DCFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/dcfl_pkg.sv =====
package dcfl_pkg;

    // Filter geometry and word widths
    localparam int TAP_COUNT    = 51;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_WIDTH   = 16;
    localparam int DC_WIDTH     = 16;

    // Base coefficient table: 51 symmetric taps, Q1.15
    localparam int BASE_TAPS = 51;
    localparam int HALF_TAPS = 26;
    localparam int HALF_COEF [HALF_TAPS] = '{
        0, 5, 13, 23, 39, 61, 91, 131, 180, 240, 312, 393, 485,
        585, 691, 801, 914, 1025, 1133, 1234, 1325, 1403, 1467, 1514, 1543, 1552
    };

    // Rescale shifts from the Q1.15 table to COEF_WIDTH
    localparam int COEF_UP   = (COEF_WIDTH >= 16) ? (COEF_WIDTH - 16) : 0;
    localparam int COEF_DOWN = (COEF_WIDTH < 16) ? (16 - COEF_WIDTH) : 1;

    // MAC lanes per channel and passes over the tap line
    localparam int LANE_COUNT = (TAP_COUNT < 4) ? TAP_COUNT : 4;
    localparam int STEP_COUNT = (TAP_COUNT + LANE_COUNT - 1) / LANE_COUNT;
    localparam int STEP_W     = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

    // Arithmetic widths
    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(TAP_COUNT) + 1;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd1 <<< (COEF_WIDTH - 2));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // Input and output words
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] ac_red;
        logic        [DC_WIDTH-1:0]     dc_red;
        logic signed [SAMPLE_WIDTH-1:0] ac_ir;
        logic        [DC_WIDTH-1:0]     dc_ir;
    } dcfl_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered_ac_red;
        logic        [DC_WIDTH-1:0]     out_dc_red;
        logic signed [SAMPLE_WIDTH-1:0] filtered_ac_ir;
        logic        [DC_WIDTH-1:0]     out_dc_ir;
    } dcfl_out_t;

    // Sequencer controls toward the channel datapaths
    typedef struct packed {
        logic              load;   // shift new sample in, reload scan line, clear sums
        logic              mac;    // multiply pass over one group of taps
        logic              acc;    // add last cycle's products
        logic [STEP_W-1:0] step;   // tap group of the current pass
    } dcfl_ctrl_t;

    // Coefficient for tap k, zero outside the base table
    function automatic logic signed [COEF_WIDTH-1:0] coef_at(input int k);
        int idx;
        int c;
        if (k < 0 || k >= BASE_TAPS)
        begin
            return '0;
        end
        idx = (k < HALF_TAPS) ? k : (BASE_TAPS - 1 - k);
        c = HALF_COEF[idx];
        if (COEF_WIDTH >= 16)
        begin
            c = c <<< COEF_UP;
        end
        else
        begin
            c = (c + (1 <<< (COEF_DOWN - 1))) >>> COEF_DOWN;
        end
        return COEF_WIDTH'(c);
    endfunction

endpackage

// ===== rtl/core/dual_channel_fir_lowpass.sv =====
// Channel   Dir  Handshake                  Word
// sample    in   sample_valid/sample_stall  dcfl_in_t  (red AC/DC, IR AC/DC)
// result    out  result_valid/result_stall  dcfl_out_t (filtered AC, DC copies)
//
// A word passes through the accept cycle, a MAC pass per group of LANE_COUNT
// taps through the MAC lanes, a drain step to add the last products and a
// merge step that rounds and loads the output register once it is free.
// Reset clears both 51-deep histories and the sequencer at once.
// A finished word waits in the output register while result_stall is high;
// sample_stall is high from accept until that register is loaded.
`include "dual_channel_fir_lowpass_macros.svh"

module dual_channel_fir_lowpass
    import dcfl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_stall,
    input  dcfl_in_t  sample_data,
    output logic      result_valid,
    input  logic      result_stall,
    output dcfl_out_t result_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_MERGE = 2'd3;

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [STEP_W-1:0]              step_reg;
    logic [STEP_W-1:0]              step_next;
    logic                           acc_en_reg;
    logic [DC_WIDTH-1:0]            dc_red_reg;
    logic [DC_WIDTH-1:0]            dc_ir_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    dcfl_out_t                      out_data_reg;
    logic                           accept;
    logic                           slot_free;
    logic                           load_out;
    dcfl_ctrl_t                     ctrl;
    logic signed [SAMPLE_WIDTH-1:0] red_filtered;
    logic signed [SAMPLE_WIDTH-1:0] ir_filtered;

    // Input side
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign slot_free    = !out_valid_reg || !result_stall;
    assign load_out     = (state_reg == ST_MERGE) && slot_free;

    // Controls to both channels
    assign ctrl.load = accept;
    assign ctrl.mac  = (state_reg == ST_MAC);
    assign ctrl.acc  = acc_en_reg;
    assign ctrl.step = step_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MAC;
                    step_next  = '0;
                end
            end
            ST_MAC:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEP_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            acc_en_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            acc_en_reg <= ctrl.mac;
        end
    end

    // DC levels ride along with the word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dc_red_reg <= sample_data.dc_red;
            dc_ir_reg  <= sample_data.dc_ir;
        end
    end

    // Filter datapaths
    dcfl_channel u_red
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample   (sample_data.ac_red),
        .filtered (red_filtered)
    );

    dcfl_channel u_ir
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample   (sample_data.ac_ir),
        .filtered (ir_filtered)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.filtered_ac_red <= red_filtered;
            out_data_reg.out_dc_red      <= dc_red_reg;
            out_data_reg.filtered_ac_ir  <= ir_filtered;
            out_data_reg.out_dc_ir       <= dc_ir_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // Checks
    `DCFL_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, accept, (state_reg == ST_MAC) && (step_reg == '0))
    `DCFL_ASSERT_IMPL(a_drain_after_mac, clk, rst_n, state_reg == ST_DRAIN, $past(state_reg) == ST_MAC)
    `DCFL_ASSERT_IMPL(a_acc_window, clk, rst_n, acc_en_reg, (state_reg == ST_MAC) || (state_reg == ST_DRAIN))
    `DCFL_ASSERT_NEXT(a_merge_waits, clk, rst_n, (state_reg == ST_MERGE) && !slot_free, (state_reg == ST_MERGE) && result_valid)

endmodule

// ===== rtl/core/dcfl_lane.sv =====
module dcfl_lane
    import dcfl_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dcfl_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic signed [COEF_WIDTH-1:0]   coef,
    output logic signed [ACC_W-1:0]        acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // Product of one tap, registered before the add
    assign prod_next = sample * coef;

    always_ff @(posedge clk)
    begin
        if (ctrl.mac)
        begin
            prod_reg <= prod_next;
        end
    end

    // Running partial sum of this lane's taps
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/core/dcfl_merge.sv =====
module dcfl_merge
    import dcfl_pkg::*;
(
    input  logic signed [ACC_W-1:0]        lane_acc [LANE_COUNT],
    output logic signed [SAMPLE_WIDTH-1:0] filtered
);

    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] rounded;

    // Combine lane sums, round half up, back to sample scale, clamp
    always_comb
    begin
        sum = '0;
        for (int j = 0; j < LANE_COUNT; j++)
        begin
            sum = sum + lane_acc[j];
        end
        rounded = (sum + ROUND_BIAS) >>> (COEF_WIDTH - 1);
        if (rounded > SAT_HI)
        begin
            filtered = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (rounded < SAT_LO)
        begin
            filtered = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            filtered = rounded[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

// ===== rtl/core/dcfl_channel.sv =====
module dcfl_channel
    import dcfl_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  dcfl_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic signed [SAMPLE_WIDTH-1:0] filtered
);

    logic signed [SAMPLE_WIDTH-1:0] hist_reg   [TAP_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] scan_reg   [TAP_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] scan_shift [TAP_COUNT];
    logic signed [COEF_WIDTH-1:0]   lane_coef  [LANE_COUNT];
    logic signed [ACC_W-1:0]        lane_acc   [LANE_COUNT];

    // Sample history, newest at index 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (ctrl.load)
        begin
            hist_reg[0] <= sample;
            for (int i = 1; i < TAP_COUNT; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // Scan line moves one tap group toward the lanes each pass
    for (genvar i = 0; i < TAP_COUNT; i++)
    begin : g_scan
        if (i + LANE_COUNT < TAP_COUNT)
        begin : g_mid
            assign scan_shift[i] = scan_reg[i+LANE_COUNT];
        end
        else
        begin : g_end
            assign scan_shift[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            scan_reg[0] <= sample;
            for (int i = 1; i < TAP_COUNT; i++)
            begin
                scan_reg[i] <= hist_reg[i-1];
            end
        end
        else if (ctrl.mac)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                scan_reg[i] <= scan_shift[i];
            end
        end
    end

    // MAC lanes: lane j handles taps step*LANE_COUNT + j
    for (genvar j = 0; j < LANE_COUNT; j++)
    begin : g_lane
        assign lane_coef[j] = coef_at(int'(ctrl.step) * LANE_COUNT + j);

        dcfl_lane u_lane
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .sample (scan_reg[j]),
            .coef   (lane_coef[j]),
            .acc    (lane_acc[j])
        );
    end

    // Lane sums to one rounded sample
    dcfl_merge u_merge
    (
        .lane_acc (lane_acc),
        .filtered (filtered)
    );

endmodule

// ===== verif/dual_channel_fir_lowpass_tb.sv =====
`timescale 1ns / 100ps

module dual_channel_fir_lowpass_tb;
    import dcfl_pkg::*;

    // Q1.15 low-pass taps, centre tap last; the line is symmetric about tap 25
    localparam int LP_HALF = 26;
    localparam int LP_TAPS = 51;
    localparam int LP_TAP_Q [LP_HALF] = '{
        0, 5, 13, 23, 39, 61, 91, 131, 180, 240, 312, 393, 485,
        585, 691, 801, 914, 1025, 1133, 1234, 1325, 1403, 1467, 1514, 1543, 1552
    };
    localparam int FRAC_BITS = 15;
    localparam longint HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint AC_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam longint AC_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
    localparam int CHAN_RED = 0;
    localparam int CHAN_IR  = 1;
    localparam int DRAIN_CYCLES = 24;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      sample_valid = 1'b0;
    logic      sample_stall;
    dcfl_in_t  sample_data = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    dcfl_out_t result_data;

    // Idle bursts on the sender and receiver sides
    logic src_idle_on = 1'b1;
    logic snk_idle_on = 1'b1;
    int   snk_idle_left = 0;

    // Filter history per AC channel, index 0 newest
    logic signed [SAMPLE_WIDTH-1:0] ac_line [2][TAP_COUNT];

    dcfl_out_t filtered_queue [$];
    int        mismatch_count = 0;

    dual_channel_fir_lowpass u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shift one sample into a channel line and return the rounded, clamped sum
    function automatic logic signed [SAMPLE_WIDTH-1:0] lowpass_sample(
        input int ch, input logic signed [SAMPLE_WIDTH-1:0] x);
        longint sum;
        int     k;
        int     idx;
        for (k = TAP_COUNT - 1; k > 0; k--)
        begin
            ac_line[ch][k] = ac_line[ch][k-1];
        end
        ac_line[ch][0] = x;
        sum = 0;
        for (k = 0; k < TAP_COUNT; k++)
        begin
            if (k < LP_TAPS)
            begin
                idx = (k < LP_HALF) ? k : (LP_TAPS - 1 - k);
                sum += longint'(LP_TAP_Q[idx]) * longint'(ac_line[ch][k]);
            end
        end
        // round half up, then floor shift back to sample scale
        sum = (sum + HALF_LSB) >>> FRAC_BITS;
        if (sum > AC_MAX)
        begin
            sum = AC_MAX;
        end
        if (sum < AC_MIN)
        begin
            sum = AC_MIN;
        end
        return SAMPLE_WIDTH'(sum);
    endfunction

    function automatic dcfl_out_t filter_word(input dcfl_in_t w);
        dcfl_out_t r;
        r.filtered_ac_red = lowpass_sample(CHAN_RED, w.ac_red);
        r.out_dc_red      = w.dc_red;
        r.filtered_ac_ir  = lowpass_sample(CHAN_IR, w.ac_ir);
        r.out_dc_ir       = w.dc_ir;
        return r;
    endfunction

    function automatic dcfl_in_t pack_word(input logic [15:0] red, input logic [15:0] ir);
        dcfl_in_t w;
        w.ac_red = red;
        w.dc_red = DC_WIDTH'($urandom);
        w.ac_ir  = ir;
        w.dc_ir  = DC_WIDTH'($urandom);
        return w;
    endfunction

    // Present one word, hold it until accepted, then record its expected result
    task automatic send_word(input dcfl_in_t w);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= w;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        filtered_queue.push_back(filter_word(w));
    endtask

    task automatic check_result(input dcfl_out_t got);
        dcfl_out_t want;
        if (filtered_queue.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t: unexpected result word %h", $realtime, got);
            end
            return;
        end
        want = filtered_queue.pop_front();
        if (got.filtered_ac_red !== want.filtered_ac_red
            || got.out_dc_red !== want.out_dc_red
            || got.filtered_ac_ir !== want.filtered_ac_ir
            || got.out_dc_ir !== want.out_dc_ir)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t: mismatch red %0d/%h ir %0d/%h, expected red %0d/%h ir %0d/%h",
                         $realtime, got.filtered_ac_red, got.out_dc_red,
                         got.filtered_ac_ir, got.out_dc_ir,
                         want.filtered_ac_red, want.out_dc_red,
                         want.filtered_ac_ir, want.out_dc_ir);
            end
        end
    endtask

    // Result side: compare accepted words
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            check_result(result_data);
        end
    end

    // Receiver stall bursts
    always @(posedge clk)
    begin
        if (snk_idle_left > 0)
        begin
            snk_idle_left <= snk_idle_left - 1;
            result_stall  <= 1'b1;
        end
        else if (snk_idle_on && $urandom_range(0, 3) == 0)
        begin
            snk_idle_left <= $urandom_range(0, 16);
            result_stall  <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Impulses, full-scale steps, bit patterns and DC extremes
    task automatic test_edge_values();
        int n;
        send_word('0);
        send_word('{16'sh7FFF, 16'h0000, 16'sh8000, 16'hFFFF});
        send_word('{16'sh0000, 16'hFFFF, 16'sh0000, 16'h0000});
        send_word('{16'sh8000, 16'hFFFF, 16'sh7FFF, 16'h0000});
        send_word('{16'sh5555, 16'hAAAA, 16'shAAAA, 16'h5555});
        send_word('{16'shAAAA, 16'h5555, 16'sh5555, 16'hAAAA});
        for (n = 0; n < 10; n++)
        begin
            send_word(pack_word(16'h7FFF, 16'h8000));
        end
        for (n = 0; n < 4; n++)
        begin
            send_word(n[0] ? pack_word(16'h7FFF, 16'h8000) : pack_word(16'h8000, 16'h7FFF));
        end
        send_word(pack_word(16'hFFFF, 16'h0001));
        send_word(pack_word(16'h0001, 16'hFFFF));
    endtask

    task automatic test_full_scale_random(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_word(pack_word(16'($urandom), 16'($urandom)));
        end
    endtask

    // Constant runs of 1 to 60 words, at the rails or at random levels
    task automatic test_constant_runs(input int count);
        int          sent;
        int          run;
        int          n;
        logic [15:0] red;
        logic [15:0] ir;
        sent = 0;
        while (sent < count)
        begin
            run = $urandom_range(1, 60);
            case ($urandom_range(0, 3))
                0: begin red = 16'h7FFF; ir = 16'h8000; end
                1: begin red = 16'h8000; ir = 16'h7FFF; end
                default: begin red = 16'($urandom); ir = 16'($urandom); end
            endcase
            for (n = 0; n < run; n++)
            begin
                send_word(pack_word(red, ir));
            end
            sent += run;
        end
    endtask

    // Tiny amplitudes land on rounding ties often
    task automatic test_small_amplitude(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            send_word(pack_word(16'($signed($urandom_range(0, 14)) - 7),
                                16'($signed($urandom_range(0, 14)) - 7)));
        end
    endtask

    task automatic test_steady_flow(input int count);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        test_full_scale_random(count);
    endtask

    initial
    begin
        int k;
        for (k = 0; k < TAP_COUNT; k++)
        begin
            ac_line[CHAN_RED][k] = '0;
            ac_line[CHAN_IR][k]  = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_values();
        test_full_scale_random(500);
        test_constant_runs(300);
        test_small_amplitude(150);
        test_steady_flow(150);

        sample_valid <= 1'b0;
        while (filtered_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== dual_channel_fir_lowpass.f =====
+incdir+rtl/core
rtl/core/dcfl_pkg.sv
rtl/core/dcfl_lane.sv
rtl/core/dcfl_merge.sv
rtl/core/dcfl_channel.sv
rtl/core/dual_channel_fir_lowpass.sv
verif/dual_channel_fir_lowpass_tb.sv
